// ----- hw/rtl/vsdt_pkg.sv -----
// Package for the voice stream demux tracker.
// Holds transaction types, status and frame codes, register indexes and constants.
// No dependencies.
package vsdt_pkg;

	// Module table sizing
	localparam int MODULE_COUNT_DEF = 3;
	localparam int MAX_TRACKED      = 3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MY_ADDRESS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULE_EN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOICE_TYPE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_PORT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_STEP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd5;

	// Configuration reset values
	localparam logic [31:0] RST_MY_ADDRESS = 32'hAC10_0014;
	localparam logic [2:0]  RST_MODULE_EN  = 3'd7;
	localparam logic [7:0]  RST_VOICE_TYPE = 8'h20;
	localparam logic [15:0] RST_BASE_PORT  = 16'd4200;
	localparam logic [15:0] RST_PORT_STEP  = 16'd1;
	localparam logic [7:0]  RST_TIMEOUT    = 8'd3;

	// Result status codes
	localparam logic [3:0] ST_FORWARDED  = 4'd0;
	localparam logic [3:0] ST_NOT_UDP    = 4'd1;
	localparam logic [3:0] ST_NOT_MINE   = 4'd2;
	localparam logic [3:0] ST_BAD_SIG    = 4'd3;
	localparam logic [3:0] ST_ACK        = 4'd4;
	localparam logic [3:0] ST_NOT_SEND   = 4'd5;
	localparam logic [3:0] ST_NOT_VOICE  = 4'd6;
	localparam logic [3:0] ST_BAD_LEN    = 4'd7;
	localparam logic [3:0] ST_BAD_CHAR   = 4'd8;
	localparam logic [3:0] ST_MODULE_OFF = 4'd9;
	localparam logic [3:0] ST_BUSY       = 4'd10;
	localparam logic [3:0] ST_UNKNOWN    = 4'd11;
	localparam logic [3:0] ST_WRONG_DIR  = 4'd12;
	localparam logic [3:0] ST_BAD_SEQ    = 4'd13;
	localparam logic [3:0] ST_TICK       = 4'd14;

	// Frame kinds
	localparam logic [1:0] KIND_HEADER   = 2'd0;
	localparam logic [1:0] KIND_VOICE    = 2'd1;
	localparam logic [1:0] KIND_VOICE_EX = 2'd2;

	// Protocol constants
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [31:0] SIG_DSTR     = 32'h4453_5452;
	localparam logic [7:0]  FLAG_ACK     = 8'h72;
	localparam logic [7:0]  FLAG_SEND    = 8'h73;
	localparam logic [15:0] LEN_VOICE    = 16'd19;
	localparam logic [15:0] LEN_VOICE_EX = 16'd22;
	localparam logic [15:0] LEN_HEADER   = 16'd48;
	localparam logic [4:0]  SEQ_MAX      = 5'd20;
	localparam int          SEQ_END_BIT  = 6;
	localparam logic [7:0]  CHAR_A       = 8'h41;
	localparam logic [7:0]  CHAR_CASE    = 8'h20;

	typedef struct packed {
		logic        command;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [7:0]  ip_protocol;
		logic [31:0] signature_word;
		logic [7:0]  send_flag;
		logic [7:0]  packet_type;
		logic [15:0] payload_length;
		logic [7:0]  repeater1_last_char;
		logic [7:0]  repeater2_last_char;
		logic [15:0] stream_ident;
		logic [7:0]  sequence_byte;
	} item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [1:0]  module_index;
		logic [1:0]  frame_kind;
		logic        outbound;
		logic [15:0] out_sequence;
		logic [15:0] out_stream;
		logic [15:0] out_port;
		logic        stream_ended;
	} result_t;

	// Stream table update command
	typedef struct packed {
		logic        tick;     // decrement nonzero hold timers
		logic        fwd;      // forwarded: reload timer, bump count
		logic        claim;    // header claims the module
		logic        finish;   // end-of-stream bit seen
		logic [1:0]  mod;
		logic [15:0] sid;
		logic        dir;
	} upd_t;

endpackage

// ----- hw/rtl/vsdt_table.sv -----
// Per-module stream table (active, stream id, direction, hold timer) and
// the forwarded-packet counter. Depends on vsdt_pkg.
module vsdt_table import vsdt_pkg::*; #(
	parameter int MODULE_COUNT = MODULE_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  upd_t                  upd,
	input  logic [7:0]            timeout_reload,
	output logic [TRACKED()-1:0]        active,
	output logic [TRACKED()-1:0][15:0]  stream,
	output logic [TRACKED()-1:0]        cdir,
	output logic [TRACKED()-1:0][7:0]   timer,
	output logic [15:0]           fwd_count
);

	function automatic int TRACKED();
		return (MODULE_COUNT < MAX_TRACKED) ? MODULE_COUNT : MAX_TRACKED;
	endfunction

	logic [TRACKED()-1:0]       active_q;
	logic [TRACKED()-1:0][15:0] stream_q;
	logic [TRACKED()-1:0]       cdir_q;
	logic [TRACKED()-1:0][7:0]  timer_q;
	logic [15:0]                count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			stream_q <= '0;
			cdir_q   <= '0;
			timer_q  <= '0;
			count_q  <= '0;
		end else if (en) begin
			for (int i = 0; i < TRACKED(); i++) begin
				if (upd.fwd && upd.mod == 2'(i)) begin
					timer_q[i] <= timeout_reload;
					if (upd.claim) begin
						active_q[i] <= 1'b1;
						stream_q[i] <= upd.sid;
						cdir_q[i]   <= upd.dir;
					end else if (upd.finish) begin
						active_q[i] <= 1'b0;
					end
				end else if (upd.tick && timer_q[i] != 8'd0) begin
					timer_q[i] <= timer_q[i] - 8'd1;
				end
			end
			if (upd.fwd)
				count_q <= count_q + 16'd1;
		end
	end

	assign active    = active_q;
	assign stream    = stream_q;
	assign cdir      = cdir_q;
	assign timer     = timer_q;
	assign fwd_count = count_q;

endmodule

// ----- hw/rtl/vsdt_classify.sv -----
// Single-pass packet check, module selection and result formatting.
// Purely combinational. Depends on vsdt_pkg.
module vsdt_classify import vsdt_pkg::*; #(
	parameter int MODULE_COUNT = MODULE_COUNT_DEF
) (
	input  item_t                       item,
	input  logic [31:0]                 my_address,
	input  logic [2:0]                  module_enable,
	input  logic [7:0]                  voice_packet_type,
	input  logic [15:0]                 base_port,
	input  logic [15:0]                 port_step,
	input  logic [TRACKED()-1:0]        active,
	input  logic [TRACKED()-1:0][15:0]  stream,
	input  logic [TRACKED()-1:0]        cdir,
	input  logic [TRACKED()-1:0][7:0]   timer,
	input  logic [15:0]                 fwd_count,
	output result_t                     res,
	output upd_t                        upd
);

	function automatic int TRACKED();
		return (MODULE_COUNT < MAX_TRACKED) ? MODULE_COUNT : MAX_TRACKED;
	endfunction

	logic        dir;
	logic        mine;
	logic [7:0]  mchar;
	logic        char_ok;
	logic [1:0]  hmod;
	logic        h_en;
	logic        h_busy;
	logic        v_hit;
	logic [1:0]  vmod;
	logic        v_dir;
	logic        is_hdr;
	logic        len_ok;
	logic [1:0]  fmod;
	logic [17:0] prod;

	always_comb begin
		dir    = (item.source_address == my_address);
		mine   = dir || (item.dest_address == my_address);
		is_hdr = (item.payload_length == LEN_HEADER);
		len_ok = is_hdr || item.payload_length == LEN_VOICE
			|| item.payload_length == LEN_VOICE_EX;
		mchar  = dir ? item.repeater2_last_char : item.repeater1_last_char;

		char_ok = 1'b1;
		case (mchar) inside
			CHAR_A, CHAR_A | CHAR_CASE:                     hmod = 2'd0;
			CHAR_A + 8'd1, (CHAR_A + 8'd1) | CHAR_CASE:     hmod = 2'd1;
			CHAR_A + 8'd2, (CHAR_A + 8'd2) | CHAR_CASE:     hmod = 2'd2;
			default: begin
				hmod    = 2'd0;
				char_ok = 1'b0;
			end
		endcase

		// Header target: enabled and busy flags of the chosen module
		h_en   = 1'b0;
		h_busy = 1'b0;
		for (int i = 0; i < TRACKED(); i++) begin
			if (hmod == 2'(i)) begin
				h_en   = module_enable[i];
				h_busy = active[i] && timer[i] != 8'd0;
			end
		end

		// Voice lookup: lowest enabled module holding this stream id
		v_hit = 1'b0;
		vmod  = 2'd0;
		v_dir = 1'b0;
		for (int i = TRACKED() - 1; i >= 0; i--) begin
			if (module_enable[i] && stream[i] == item.stream_ident) begin
				v_hit = 1'b1;
				vmod  = 2'(i);
				v_dir = cdir[i];
			end
		end

		fmod = is_hdr ? hmod : vmod;
		prod = 18'(port_step) * 18'(fmod);

		res        = '0;
		upd        = '0;
		upd.mod    = fmod;
		upd.sid    = item.stream_ident;
		upd.dir    = dir;

		if (item.command) begin
			res.status = ST_TICK;
			upd.tick   = 1'b1;
		end else if (item.ip_protocol != PROTO_UDP) begin
			res.status = ST_NOT_UDP;
		end else if (!mine) begin
			res.status = ST_NOT_MINE;
		end else if (item.signature_word != SIG_DSTR) begin
			res.status = ST_BAD_SIG;
		end else if (item.send_flag == FLAG_ACK) begin
			res.status = ST_ACK;
		end else if (item.send_flag != FLAG_SEND) begin
			res.status = ST_NOT_SEND;
		end else if (item.packet_type != voice_packet_type) begin
			res.status = ST_NOT_VOICE;
		end else if (!len_ok) begin
			res.status = ST_BAD_LEN;
		end else if (is_hdr && !char_ok) begin
			res.status = ST_BAD_CHAR;
		end else if (is_hdr && !h_en) begin
			res.status = ST_MODULE_OFF;
		end else if (is_hdr && h_busy) begin
			res.status = ST_BUSY;
		end else if (!is_hdr && !v_hit) begin
			res.status = ST_UNKNOWN;
		end else if (!is_hdr && dir != v_dir) begin
			res.status = ST_WRONG_DIR;
		end else if (!is_hdr && item.sequence_byte[4:0] > SEQ_MAX) begin
			res.status = ST_BAD_SEQ;
		end else begin
			res.status       = ST_FORWARDED;
			res.module_index = fmod;
			res.outbound     = dir;
			res.out_sequence = fwd_count;
			res.out_stream   = item.stream_ident;
			res.out_port     = base_port + prod[15:0];
			if (is_hdr)
				res.frame_kind = KIND_HEADER;
			else if (item.payload_length == LEN_VOICE)
				res.frame_kind = KIND_VOICE;
			else
				res.frame_kind = KIND_VOICE_EX;
			res.stream_ended = !is_hdr && item.sequence_byte[SEQ_END_BIT];
			upd.fwd          = 1'b1;
			upd.claim        = is_hdr;
			upd.finish       = !is_hdr && item.sequence_byte[SEQ_END_BIT];
		end
	end

endmodule

// ----- hw/rtl/voice_stream_demux_tracker.sv -----
// Voice stream demux tracker, top level.
// A transaction accepted into the input register is checked combinationally and lands in the
// result register when the stage advances; a blocked output can stall it in between.
// Throughput: one transaction per cycle while the output is not blocked.
// Reset (arst_n low, asynchronous): stream table, counter and handshake state
// clear at once; configuration registers return to their defaults.
//
// Depends on vsdt_pkg, vsdt_classify and vsdt_table.
module voice_stream_demux_tracker import vsdt_pkg::*; #(
	parameter int MODULE_COUNT = MODULE_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	// result channel
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	function automatic int TRACKED();
		return (MODULE_COUNT < MAX_TRACKED) ? MODULE_COUNT : MAX_TRACKED;
	endfunction

	// Configuration registers
	logic [31:0] my_address_q;
	logic [2:0]  module_enable_q;
	logic [7:0]  voice_type_q;
	logic [15:0] base_port_q;
	logic [15:0] port_step_q;
	logic [7:0]  timeout_q;

	// Input stage and result register
	logic    valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;

	// Handshake control: the stage advances whenever the result slot is free
	// or its contents are being taken this cycle.
	logic    advance;
	logic    fire;

	// Table view and decision
	logic [TRACKED()-1:0]       active;
	logic [TRACKED()-1:0][15:0] stream;
	logic [TRACKED()-1:0]       cdir;
	logic [TRACKED()-1:0][7:0]  timer;
	logic [15:0]                fwd_count;
	result_t                    res;
	upd_t                       upd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_address_q    <= RST_MY_ADDRESS;
			module_enable_q <= RST_MODULE_EN;
			voice_type_q    <= RST_VOICE_TYPE;
			base_port_q     <= RST_BASE_PORT;
			port_step_q     <= RST_PORT_STEP;
			timeout_q       <= RST_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MY_ADDRESS: my_address_q    <= cfg_data;
				REG_MODULE_EN:  module_enable_q <= cfg_data[2:0];
				REG_VOICE_TYPE: voice_type_q    <= cfg_data[7:0];
				REG_BASE_PORT:  base_port_q     <= cfg_data[15:0];
				REG_PORT_STEP:  port_step_q     <= cfg_data[15:0];
				REG_TIMEOUT:    timeout_q       <= cfg_data[7:0];
				default: ;   // indexes past the list are dropped
			endcase
		end
	end

	assign advance    = !result_valid_q || result_ready;
	assign fire       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	// Input register: takes a new transaction whenever the held one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_ready)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	vsdt_classify #(
		.MODULE_COUNT(MODULE_COUNT)
	) u_classify (
		.item              (item_s1),
		.my_address        (my_address_q),
		.module_enable     (module_enable_q),
		.voice_packet_type (voice_type_q),
		.base_port         (base_port_q),
		.port_step         (port_step_q),
		.active            (active),
		.stream            (stream),
		.cdir              (cdir),
		.timer             (timer),
		.fwd_count         (fwd_count),
		.res               (res),
		.upd               (upd)
	);

	// Table commits in the same cycle the result is registered, so the
	// next transaction in the input stage already sees the new state.
	vsdt_table #(
		.MODULE_COUNT(MODULE_COUNT)
	) u_table (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (fire),
		.upd            (upd),
		.timeout_reload (timeout_q),
		.active         (active),
		.stream         (stream),
		.cdir           (cdir),
		.timer          (timer),
		.fwd_count      (fwd_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (advance)
			result_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// Input side only stalls when both stages are full and the output is blocked
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && result_valid_q && !result_ready)
		else $error("item_ready low without a blocked pipeline");

	// Counter moves by one exactly on each forwarded transaction
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.status == ST_FORWARDED |=> fwd_count == $past(fwd_count) + 16'd1)
		else $error("forward counter did not advance on forward");

	// Rejected and tick results carry only a status
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status != ST_FORWARDED |->
			result_q.out_port == 16'd0 && result_q.out_sequence == 16'd0
			&& result_q.out_stream == 16'd0 && !result_q.stream_ended)
		else $error("non-forward result has nonzero fields");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the voice stream demux tracker: self-checking, random bursts and stalls.
// Depends on vsdt_pkg and voice_stream_demux_tracker, which in turn needs vsdt_classify and vsdt_table.
module tb_top;
	import vsdt_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int LIMIT_CYCLES = 1_200_000;

	// Index codes past the end of the register file; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Receiver stall patterns
	typedef enum int {RX_OPEN, RX_COIN, RX_PULSE, RX_LIGHT} rx_mode_e;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_ready;
	item_t                item         = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [31:0]          cfg_data     = '0;

	// Mirror of the configuration registers, updated when a write transaction completes.
	logic [31:0] cf_addr   = RST_MY_ADDRESS;
	logic [2:0]  cf_en     = RST_MODULE_EN;
	logic [7:0]  cf_vtype  = RST_VOICE_TYPE;
	logic [15:0] cf_base   = RST_BASE_PORT;
	logic [15:0] cf_step   = RST_PORT_STEP;
	logic [7:0]  cf_reload = RST_TIMEOUT;

	// Mirror of the stream table.
	logic [MODULE_COUNT_DEF-1:0] live      = '0;
	logic [MODULE_COUNT_DEF-1:0] claim_out = '0;
	logic [15:0]                 claim_sid [MODULE_COUNT_DEF];
	logic [7:0]                  hold      [MODULE_COUNT_DEF];
	logic [15:0]                 fwd_count = '0;

	// Stimulus side: what the generator last announced per module (may be stale).
	logic [15:0] gen_sid [MODULE_COUNT_DEF];
	logic        gen_dir [MODULE_COUNT_DEF];

	item_t   packet_q[$];   // packets and ticks waiting for the driver
	result_t outcome_q[$];  // predicted results, oldest first
	int      mismatches = 0;

	// Sender burst shaping
	int burst_left = 1;
	int gap_left   = 0;

	// Receiver stall shaping
	rx_mode_e    stall_mode = RX_OPEN;
	int          mode_left  = 0;
	logic [31:0] rx_cycle   = '0;

	voice_stream_demux_tracker uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Outcome of one accepted transaction; advances the mirrored table and counter.
	function automatic result_t demux_outcome(input item_t it);
		result_t    r;
		logic       dir;
		logic [7:0] folded;
		int         m;
		r = '0;
		m = -1;
		if (it.command) begin
			for (int i = 0; i < MODULE_COUNT_DEF; i++)
				if (hold[i] != 0)
					hold[i] = hold[i] - 1'b1;
			r.status = ST_TICK;
			return r;
		end
		if (it.ip_protocol != PROTO_UDP) begin
			r.status = ST_NOT_UDP;
			return r;
		end
		// own source address wins when both match
		if (it.source_address == cf_addr) begin
			dir = 1'b1;
		end else if (it.dest_address == cf_addr) begin
			dir = 1'b0;
		end else begin
			r.status = ST_NOT_MINE;
			return r;
		end
		if (it.signature_word != SIG_DSTR) begin
			r.status = ST_BAD_SIG;
			return r;
		end
		if (it.send_flag == FLAG_ACK) begin
			r.status = ST_ACK;
			return r;
		end
		if (it.send_flag != FLAG_SEND) begin
			r.status = ST_NOT_SEND;
			return r;
		end
		if (it.packet_type != cf_vtype) begin
			r.status = ST_NOT_VOICE;
			return r;
		end
		if (it.payload_length != LEN_VOICE && it.payload_length != LEN_VOICE_EX &&
				it.payload_length != LEN_HEADER) begin
			r.status = ST_BAD_LEN;
			return r;
		end
		if (it.payload_length == LEN_HEADER) begin
			// case folding maps A..C and a..c onto a..c and nothing else there
			folded = (dir ? it.repeater2_last_char : it.repeater1_last_char) | CHAR_CASE;
			if (folded < (CHAR_A | CHAR_CASE) || folded > (CHAR_A | CHAR_CASE) + 2) begin
				r.status = ST_BAD_CHAR;
				return r;
			end
			m = int'(folded - (CHAR_A | CHAR_CASE));
			if (!cf_en[m]) begin
				r.status = ST_MODULE_OFF;
				return r;
			end
			if (live[m] && hold[m] != 0) begin
				r.status = ST_BUSY;
				return r;
			end
			claim_sid[m] = it.stream_ident;
			claim_out[m] = dir;
			live[m]      = 1'b1;
			r.frame_kind = KIND_HEADER;
		end else begin
			// lowest enabled module wins; an ended stream still matches
			for (int i = 0; i < MODULE_COUNT_DEF; i++)
				if (m < 0 && cf_en[i] && claim_sid[i] == it.stream_ident)
					m = i;
			if (m < 0) begin
				r.status = ST_UNKNOWN;
				return r;
			end
			if (dir != claim_out[m]) begin
				r.status = ST_WRONG_DIR;
				return r;
			end
			if (it.sequence_byte[4:0] > SEQ_MAX) begin
				r.status = ST_BAD_SEQ;
				return r;
			end
			if (it.sequence_byte[SEQ_END_BIT]) begin
				live[m]        = 1'b0;
				r.stream_ended = 1'b1;
			end
			r.frame_kind = (it.payload_length == LEN_VOICE) ? KIND_VOICE : KIND_VOICE_EX;
		end
		r.status       = ST_FORWARDED;
		r.module_index = m[1:0];
		r.outbound     = dir;
		r.out_sequence = fwd_count;
		r.out_stream   = it.stream_ident;
		r.out_port     = cf_base + 16'(m) * cf_step;
		fwd_count      = fwd_count + 1'b1;
		hold[m]        = cf_reload;
		return r;
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("st=%0d mod=%0d kind=%0d outb=%0d seq=%h sid=%h port=%h end=%0d",
			r.status, r.module_index, r.frame_kind, r.outbound, r.out_sequence,
			r.out_stream, r.out_port, r.stream_ended);
	endfunction

	function automatic item_t random_item(input logic cmd);
		item_t it;
		it.command             = cmd;
		it.source_address      = $urandom();
		it.dest_address        = $urandom();
		it.ip_protocol         = 8'($urandom());
		it.signature_word      = $urandom();
		it.send_flag           = 8'($urandom());
		it.packet_type         = 8'($urandom());
		it.payload_length      = 16'($urandom());
		it.repeater1_last_char = 8'($urandom());
		it.repeater2_last_char = 8'($urandom());
		it.stream_ident        = 16'($urandom());
		it.sequence_byte       = 8'($urandom());
		return it;
	endfunction

	// Well-formed packet for the current settings; everything not checked is random.
	function automatic item_t make_packet(input logic outb, input logic [15:0] len,
			input logic [15:0] sid);
		item_t it;
		it = random_item(1'b0);
		if (outb) begin
			it.source_address = cf_addr;
		end else begin
			it.dest_address = cf_addr;
			if (it.source_address == cf_addr)
				it.source_address = ~cf_addr;
		end
		it.ip_protocol    = PROTO_UDP;
		it.signature_word = SIG_DSTR;
		it.send_flag      = FLAG_SEND;
		it.packet_type    = cf_vtype;
		it.payload_length = len;
		it.stream_ident   = sid;
		return it;
	endfunction

	function automatic item_t make_header(input logic outb, input logic [7:0] chr,
			input logic [15:0] sid);
		item_t it;
		it = make_packet(outb, LEN_HEADER, sid);
		if (outb)
			it.repeater2_last_char = chr;
		else
			it.repeater1_last_char = chr;
		return it;
	endfunction

	function automatic item_t make_voice(input logic outb, input logic [15:0] len,
			input logic [15:0] sid, input logic [7:0] seq);
		item_t it;
		it = make_packet(outb, len, sid);
		it.sequence_byte = seq;
		return it;
	endfunction

	// Driver: refills the item slot from packet_q; bursts of random length, random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				outcome_q.push_back(demux_outcome(item));
			if (!item_valid || item_ready) begin
				if (gap_left != 0) begin
					gap_left = gap_left - 1;
					item_valid <= 1'b0;
				end else if (packet_q.size() != 0) begin
					item <= packet_q.pop_front();
					item_valid <= 1'b1;
					burst_left = burst_left - 1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						// mostly short gaps, now and then a long one
						gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
							: $urandom_range(0, 4);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transaction, then picks the next ready value.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (outcome_q.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result: %s", show(result));
				end else begin
					want = outcome_q.pop_front();
					if (result.status !== want.status ||
							result.module_index !== want.module_index ||
							result.frame_kind !== want.frame_kind ||
							result.outbound !== want.outbound ||
							result.out_sequence !== want.out_sequence ||
							result.out_stream !== want.out_stream ||
							result.out_port !== want.out_port ||
							result.stream_ended !== want.stream_ended) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: expected %s, actual %s", show(want),
								show(result));
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = rx_mode_e'($urandom_range(0, 3));
				mode_left  = $urandom_range(8, 80);
			end
			mode_left = mode_left - 1;
			rx_cycle  = rx_cycle + 1;
			case (stall_mode)
				RX_OPEN:  result_ready <= 1'b1;
				RX_COIN:  result_ready <= 1'($urandom_range(0, 1));
				RX_PULSE: result_ready <= (rx_cycle[1:0] == 2'b00);
				default:  result_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// One register write transaction; the mirror follows at the accepting edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MY_ADDRESS: cf_addr   = val;
			REG_MODULE_EN:  cf_en     = val[2:0];
			REG_VOICE_TYPE: cf_vtype  = val[7:0];
			REG_BASE_PORT:  cf_base   = val[15:0];
			REG_PORT_STEP:  cf_step   = val[15:0];
			REG_TIMEOUT:    cf_reload = val[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input logic [31:0] addr, input logic [2:0] en,
			input logic [7:0] vtype, input logic [15:0] base, input logic [15:0] step,
			input logic [7:0] reload);
		write_reg(REG_MY_ADDRESS, addr);
		write_reg(REG_MODULE_EN, 32'(en));
		write_reg(REG_VOICE_TYPE, 32'(vtype));
		write_reg(REG_BASE_PORT, 32'(base));
		write_reg(REG_PORT_STEP, 32'(step));
		write_reg(REG_TIMEOUT, 32'(reload));
	endtask

	// Block is idle once nothing is queued, in the slot, or awaiting a result.
	task automatic drain();
		do @(negedge clk);
		while (packet_q.size() != 0 || item_valid || outcome_q.size() != 0);
	endtask

	// Mostly headers and voice frames on announced streams, plus ticks and damaged packets.
	task automatic random_phase(input int n);
		item_t       it;
		int          roll;
		int          m;
		logic        outb;
		logic [15:0] sid;
		logic [15:0] len;
		logic [7:0]  seq;
		logic [7:0]  chr;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			m    = $urandom_range(0, MODULE_COUNT_DEF - 1);
			outb = 1'($urandom_range(0, 1));
			len  = $urandom_range(0, 1) ? LEN_VOICE : LEN_VOICE_EX;
			seq  = 8'($urandom());
			seq[4:0] = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(21, 31)
				: $urandom_range(0, 20));
			seq[SEQ_END_BIT] = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 9))
				0:       sid = gen_sid[$urandom_range(0, MODULE_COUNT_DEF - 1)];
				1:       sid = 16'hFFFF;
				2:       sid = 16'h0000;
				default: sid = 16'($urandom());
			endcase
			chr = 8'(CHAR_A + m);
			if ($urandom_range(0, 1))
				chr = chr | CHAR_CASE;
			if ($urandom_range(0, 9) == 0)
				chr = 8'($urandom());
			if (roll < 10) begin
				it = random_item(1'b1);
			end else if (roll < 28) begin
				it = make_header(outb, chr, sid);
				gen_sid[m] = sid;
				gen_dir[m] = outb;
			end else if (roll < 80) begin
				// follow an announced stream, occasionally from the wrong side or an odd id
				if ($urandom_range(0, 11) != 0)
					sid = gen_sid[m];
				outb = gen_dir[m] ^ ($urandom_range(0, 11) == 0);
				it = make_voice(outb, len, sid, seq);
			end else begin
				it = $urandom_range(0, 1) ? make_voice(gen_dir[m], len, gen_sid[m], seq)
					: make_header(outb, chr, sid);
				// damage one stage of the check chain, or replace the packet with a random one
				case ($urandom_range(0, 7))
					0: it.ip_protocol = 8'($urandom());
					1: begin
						it.source_address = $urandom();
						it.dest_address   = $urandom();
					end
					2: it.signature_word = it.signature_word ^ (32'd1 << $urandom_range(0, 31));
					3: it.send_flag = FLAG_ACK;
					4: it.send_flag = 8'($urandom());
					5: it.packet_type = it.packet_type ^ (8'd1 << $urandom_range(0, 7));
					6: it.payload_length = $urandom_range(0, 1) ? 16'($urandom())
						: it.payload_length ^ (16'd1 << $urandom_range(0, 15));
					default: it = random_item(1'b0);
				endcase
			end
			packet_q.push_back(it);
		end
		drain();
	endtask

	initial begin
		item_t it;
		for (int i = 0; i < MODULE_COUNT_DEF; i++) begin
			claim_sid[i] = '0;
			hold[i]      = '0;
			gen_sid[i]   = '0;
			gen_dir[i]   = 1'b0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass on reset settings: each rejection, claim, busy, expiry and end.
		packet_q.push_back(random_item(1'b1));            // tick with all timers at zero
		it = make_voice(1'b0, LEN_VOICE, 16'h0000, 8'h00);
		it.ip_protocol = 8'h00;
		packet_q.push_back(it);
		it.ip_protocol = 8'hFF;
		packet_q.push_back(it);
		it = make_voice(1'b0, LEN_VOICE, 16'h0000, 8'h00);
		it.source_address = 32'h0000_0000;
		it.dest_address   = 32'hFFFF_FFFF;
		packet_q.push_back(it);                            // neither address is ours
		it = make_header(1'b1, CHAR_A, 16'h0001);
		it.dest_address = cf_addr;                         // both ours: outbound wins
		packet_q.push_back(it);
		it = make_voice(1'b0, LEN_VOICE, 16'h0001, 8'h00);
		it.signature_word = ~SIG_DSTR;
		packet_q.push_back(it);
		it.signature_word = SIG_DSTR;
		it.send_flag = FLAG_ACK;
		packet_q.push_back(it);
		it.send_flag = 8'hFF;
		packet_q.push_back(it);
		it.send_flag = FLAG_SEND;
		it.packet_type = ~cf_vtype;
		packet_q.push_back(it);
		it.packet_type = cf_vtype;
		it.payload_length = 16'h0000;
		packet_q.push_back(it);
		it.payload_length = LEN_HEADER + 1'b1;
		packet_q.push_back(it);
		packet_q.push_back(make_header(1'b0, 8'(CHAR_A + 3), 16'h2222));   // no such module
		packet_q.push_back(make_header(1'b0, 8'h00, 16'h2222));
		packet_q.push_back(make_header(1'b0, 8'(CHAR_A + 1) | CHAR_CASE, 16'hFFFF));
		packet_q.push_back(make_header(1'b0, 8'(CHAR_A + 1), 16'h7777));  // still held
		packet_q.push_back(make_voice(1'b0, LEN_VOICE, 16'hFFFF, 8'(SEQ_MAX)));
		packet_q.push_back(make_voice(1'b1, LEN_VOICE_EX, 16'hFFFF, 8'h00));
		packet_q.push_back(make_voice(1'b0, LEN_VOICE_EX, 16'hFFFF, 8'(SEQ_MAX) + 1'b1));
		packet_q.push_back(make_voice(1'b0, LEN_VOICE, 16'h1234, 8'h00));
		// end bit with the ignored upper bits set
		packet_q.push_back(make_voice(1'b0, LEN_VOICE_EX, 16'hFFFF, 8'hE5));
		packet_q.push_back(make_header(1'b1, 8'(CHAR_A + 2), 16'h0000));
		packet_q.push_back(make_header(1'b1, 8'(CHAR_A + 2) | CHAR_CASE, 16'h4242));
		repeat (3) packet_q.push_back(random_item(1'b1));
		packet_q.push_back(make_header(1'b1, 8'(CHAR_A + 2), 16'h4242));  // timer expired
		drain();

		random_phase(220);

		// Low extremes; zero reload means a claim is never held.
		set_config(32'h0000_0000, 3'd7, 8'h00, 16'h0000, 16'h0000, 8'h00);
		random_phase(150);

		// High extremes with every module off.
		set_config(32'hFFFF_FFFF, 3'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		random_phase(60);

		// Writes past the register file change nothing.
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		set_config($urandom(), 3'd5, 8'($urandom()), 16'hFFFF, 16'h0001, 8'h01);
		random_phase(150);

		set_config($urandom(), 3'd3, 8'($urandom()), 16'($urandom()), 16'($urandom()),
			8'hFF);
		random_phase(150);

		// One long outbound stream on module A; end whatever A still holds first.
		set_config(RST_MY_ADDRESS, 3'd7, RST_VOICE_TYPE, RST_BASE_PORT, 16'd7, 8'd2);
		if (live[0])
			packet_q.push_back(make_voice(claim_out[0], LEN_VOICE, claim_sid[0], 8'h40));
		packet_q.push_back(make_header(1'b1, CHAR_A, 16'h5A5A));
		gen_sid[0] = 16'h5A5A;
		gen_dir[0] = 1'b1;
		repeat (24)
			packet_q.push_back(make_voice(1'b1, $urandom_range(0, 1) ? LEN_VOICE : LEN_VOICE_EX,
				16'h5A5A, 8'($urandom_range(0, 20))));
		drain();
		random_phase(100);

		// let any stray result surface before the verdict
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/vsdt_pkg.sv
hw/rtl/vsdt_table.sv
hw/rtl/vsdt_classify.sv
hw/rtl/voice_stream_demux_tracker.sv
verif/tb_top.sv
